// File: design/ascii_graymap_parser_core_assert.svh
// Assertion macros used by the checker module.
`ifndef ASCII_GRAYMAP_PARSER_CORE_ASSERT_SVH
`define ASCII_GRAYMAP_PARSER_CORE_ASSERT_SVH

// Same-cycle implication.
`define AGP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define AGP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: design/agp_pkg.sv
package agp_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 4096;

   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_HASH  = 8'd35;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_TWO   = 8'd50;
   localparam logic [7:0] CH_P     = 8'd80;

   localparam logic [7:0] GRAY_MAX = 8'd255;

   typedef struct packed {
      logic [7:0] byte_req;
      logic       end_of_stream;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [23:0] pixel_index;
      logic [7:0]  pixel_value;
      logic [12:0] width;
      logic [12:0] height;
      logic [7:0]  max_value;
      logic        status;
      logic        last_of_run;
   } rsp_type;

endpackage

// File: design/ascii_graymap_parser_core.sv
// ASCII graymap (P2) stream parser.
// Input channel (req_*): one character per transaction; end_of_stream = 1
// closes the stream and its byte is ignored.
// Result channel (rsp_*): kind 0 carries a finished pixel with its raster
// index, kind 1 the final status (0 ok, 1 error) and the pixel count.
// A pixel is reported when the whitespace that ends it is accepted; an
// end-of-stream transaction reports a pending pixel first, then the status.
// With an empty queue a result appears on rsp_* in the cycle after the
// transaction that causes it; the status behind a flushed pixel is
// offered once that pixel is taken. One character per cycle while not
// stalled; the parser state is updated by one pass of logic per character.
// Results go through a 4-entry output queue. req_stall rises while fewer
// than two entries are free, so a stalled receiver backs up into the input
// after two to three result-producing transactions; nothing is dropped.
// Reset (synchronous, active high) empties the queue and returns the parser
// to waiting for the magic 'P'. After a status result the parser is back in
// that same state, ready for the next stream.
module ascii_graymap_parser_core #(
   parameter int unsigned MAX_DIM = agp_pkg::MAX_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  agp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output agp_pkg::rsp_type rsp_data
);
   import agp_pkg::*;

   localparam int unsigned DIM_W = $clog2(MAX_DIM + 2);
   localparam int unsigned CNT_W = 2 * DIM_W;
   localparam int unsigned MAC_W = DIM_W + 4;
   localparam logic [DIM_W-1:0] DIM_SAT = DIM_W'(MAX_DIM + 1);

   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

   localparam logic [3:0] PH_P    = 4'd0;
   localparam logic [3:0] PH_2    = 4'd1;
   localparam logic [3:0] PH_SEP0 = 4'd2;
   localparam logic [3:0] PH_SEPW = 4'd3;
   localparam logic [3:0] PH_W    = 4'd4;
   localparam logic [3:0] PH_SEPH = 4'd5;
   localparam logic [3:0] PH_H    = 4'd6;
   localparam logic [3:0] PH_SEPM = 4'd7;
   localparam logic [3:0] PH_M    = 4'd8;
   localparam logic [3:0] PH_SEPX = 4'd9;
   localparam logic [3:0] PH_X    = 4'd10;
   localparam logic [3:0] PH_ERR  = 4'd11;

   logic [3:0]       phase_ff, phase_in;
   logic             comment_ff, comment_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [8:0]       max_ff, max_in;
   logic [7:0]       pixel_acc_ff, pixel_acc_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] total_ff, total_in;

   rsp_type          q_ff [Q_DEPTH];
   logic [Q_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]    fill_ff, fill_in;

   logic             accept, pop, run;
   logic [7:0]       c;
   logic [3:0]       dig_val;
   logic             is_ws, is_dig;
   logic [MAC_W-1:0] w_mac, h_mac;
   logic [12:0]      m_mac;
   logic [7:0]       p_mac;
   logic [CNT_W-1:0] count_inc, product;
   logic [DIM_W+12:0] w_ext, h_ext;
   logic [CNT_W+23:0] idx_ext, idx_inc_ext;
   logic [7:0]       max_out;
   logic             stream_ok;
   rsp_type          res0, res1;
   logic [1:0]       push_n;

   assign accept  = req_valid && !req_stall;
   assign pop     = rsp_valid && !rsp_stall;
   assign c       = req_data.byte_req;
   assign dig_val = c[3:0];
   assign is_ws   = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   assign is_dig  = (c >= CH_ZERO) && (c <= CH_NINE);

   assign w_mac = MAC_W'(width_ff) * MAC_W'(10) + MAC_W'(dig_val);
   assign h_mac = MAC_W'(height_ff) * MAC_W'(10) + MAC_W'(dig_val);
   assign m_mac = 13'(max_ff) * 13'd10 + 13'(dig_val);
   assign p_mac = pixel_acc_ff * 8'd10 + 8'(dig_val);

   assign count_inc = count_ff + CNT_W'(1);
   assign product   = CNT_W'(width_ff) * CNT_W'(height_ff);

   // outputs report fixed-width views of the accumulators
   assign w_ext       = {13'd0, width_ff};
   assign h_ext       = {13'd0, height_ff};
   assign idx_ext     = {24'd0, count_ff};
   assign idx_inc_ext = {24'd0, count_inc};
   assign max_out     = (max_ff > 9'(GRAY_MAX)) ? GRAY_MAX : max_ff[7:0];

   assign stream_ok = (phase_ff == PH_SEPX && count_ff == total_ff) ||
                      (phase_ff == PH_X && count_inc == total_ff);

   always_comb begin
      phase_in     = phase_ff;
      comment_in   = comment_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      max_in       = max_ff;
      pixel_acc_in = pixel_acc_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      push_n       = 2'd0;
      run          = 1'b0;

      res0.kind        = KIND_PIXEL;
      res0.pixel_index = idx_ext[23:0];
      res0.pixel_value = pixel_acc_ff;
      res0.width       = w_ext[12:0];
      res0.height      = h_ext[12:0];
      res0.max_value   = max_out;
      res0.status      = STATUS_OK;
      res0.last_of_run = 1'b1;
      res1             = res0;

      if (accept) begin
         if (req_data.end_of_stream) begin
            if (phase_ff == PH_X) begin
               res0.last_of_run = 1'b0;
               res1.kind        = KIND_STATUS;
               res1.pixel_index = idx_inc_ext[23:0];
               res1.pixel_value = 8'd0;
               res1.status      = stream_ok ? STATUS_OK : STATUS_ERR;
               push_n           = 2'd2;
            end else begin
               res0.kind        = KIND_STATUS;
               res0.pixel_value = 8'd0;
               res0.status      = stream_ok ? STATUS_OK : STATUS_ERR;
               push_n           = 2'd1;
            end
            phase_in     = PH_P;
            comment_in   = 1'b0;
            width_in     = '0;
            height_in    = '0;
            max_in       = '0;
            pixel_acc_in = '0;
            count_in     = '0;
            total_in     = '0;
         end else begin
            // a comment swallows bytes; the closing newline is parsed normally
            if (comment_ff) begin
               if (c == CH_LF) begin
                  comment_in = 1'b0;
                  run        = 1'b1;
               end
            end else if (c == CH_HASH) begin
               comment_in = 1'b1;
            end else begin
               run = 1'b1;
            end
         end
      end

      if (run) begin
         unique case (phase_ff) inside
            PH_P: begin
               phase_in = (c == CH_P) ? PH_2 : PH_ERR;
            end
            PH_2: begin
               phase_in = (c == CH_TWO) ? PH_SEP0 : PH_ERR;
            end
            PH_SEP0: begin
               phase_in = is_ws ? PH_SEPW : PH_ERR;
            end
            PH_SEPW, PH_W: begin
               if (is_dig) begin
                  width_in = (w_mac > MAC_W'(MAX_DIM)) ? DIM_SAT : w_mac[DIM_W-1:0];
                  phase_in = PH_W;
               end else if (is_ws) begin
                  if (phase_ff == PH_W) phase_in = PH_SEPH;
               end else begin
                  phase_in = PH_ERR;
               end
            end
            PH_SEPH, PH_H: begin
               if (is_dig) begin
                  height_in = (h_mac > MAC_W'(MAX_DIM)) ? DIM_SAT : h_mac[DIM_W-1:0];
                  phase_in  = PH_H;
               end else if (is_ws) begin
                  if (phase_ff == PH_H) begin
                     if (width_ff == DIM_SAT || height_ff == DIM_SAT) begin
                        phase_in = PH_ERR;
                     end else begin
                        total_in = product;
                        phase_in = PH_SEPM;
                     end
                  end
               end else begin
                  phase_in = PH_ERR;
               end
            end
            PH_SEPM, PH_M: begin
               if (is_dig) begin
                  max_in   = (m_mac > 13'(GRAY_MAX)) ? 9'd256 : m_mac[8:0];
                  phase_in = PH_M;
               end else if (is_ws) begin
                  if (phase_ff == PH_M) begin
                     phase_in = (max_ff > 9'(GRAY_MAX)) ? PH_ERR : PH_SEPX;
                  end
               end else begin
                  phase_in = PH_ERR;
               end
            end
            PH_SEPX, PH_X: begin
               if (is_dig && count_ff < total_ff) begin
                  pixel_acc_in = p_mac;
                  phase_in     = PH_X;
               end else if (is_ws) begin
                  if (phase_ff == PH_X) begin
                     push_n       = 2'd1;
                     count_in     = count_inc;
                     pixel_acc_in = '0;
                     phase_in     = PH_SEPX;
                  end
               end else begin
                  phase_in = PH_ERR;
               end
            end
            default: begin
               phase_in = PH_ERR;
            end
         endcase
      end
   end

   // output queue
   assign wr_ptr_in = wr_ptr_ff + Q_AW'(push_n);
   assign rd_ptr_in = pop ? rd_ptr_ff + Q_AW'(1) : rd_ptr_ff;
   assign fill_in   = fill_ff + (Q_AW + 1)'(push_n) - (Q_AW + 1)'(pop);

   assign req_stall = fill_ff > (Q_AW + 1)'(Q_DEPTH - 2);
   assign rsp_valid = fill_ff != '0;
   assign rsp_data  = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) q_ff[wr_ptr_ff] <= res0;
      if (push_n == 2'd2) q_ff[wr_ptr_ff + Q_AW'(1)] <= res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_P;
         comment_ff   <= 1'b0;
         width_ff     <= '0;
         height_ff    <= '0;
         max_ff       <= '0;
         pixel_acc_ff <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         comment_ff   <= comment_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         max_ff       <= max_in;
         pixel_acc_ff <= pixel_acc_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
      end
   end

endmodule

// File: design/agp_checker.sv
`include "ascii_graymap_parser_core_assert.svh"

module agp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input agp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input agp_pkg::rsp_type rsp_data
);
   import agp_pkg::*;

   // a status always closes its transaction's results
   `AGP_ASSERT_IMP(a_status_last, clock, reset,
      rsp_valid && rsp_data.kind == KIND_STATUS,
      rsp_data.last_of_run && rsp_data.pixel_value == 8'd0)

   // a flushed pixel is immediately followed by its status
   `AGP_ASSERT_NEXT(a_flush_then_status, clock, reset,
      rsp_valid && !rsp_stall && rsp_data.kind == KIND_PIXEL && !rsp_data.last_of_run,
      rsp_valid && rsp_data.kind == KIND_STATUS)

   // end of stream always produces a result on the next cycle
   `AGP_ASSERT_NEXT(a_eos_result, clock, reset,
      req_valid && !req_stall && req_data.end_of_stream,
      rsp_valid)

   `AGP_ASSERT_NEXT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))

endmodule

bind ascii_graymap_parser_core agp_checker u_agp_checker (.*);
